### hw/rtl/blru_pkg.sv
// shared types, codes and constants of the budgeted lru residency manager
package blru_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam logic [39:0] DEFAULT_BUDGET = 40'd1073741824;

    // register index, taken from paddr[3]
    localparam logic REG_BYTE_BUDGET = 1'b0;

    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_ACCESS   = 2'd1;
    localparam logic [1:0] MODE_EVICT    = 2'd2;

    typedef enum logic [2:0] {
        STAT_REGISTERED = 3'd0,
        STAT_HIT        = 3'd1,
        STAT_PAGED_IN   = 3'd2,
        STAT_VICTIM     = 3'd3,
        STAT_EVICTED    = 3'd4,
        STAT_NOT_RES    = 3'd5,
        STAT_ERROR      = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ_T,
        ST_FIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_DONE,
        ST_PAGE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  entry_id;
        logic [31:0] entry_bytes;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  result_id;
        logic [39:0] bytes_in_use;
        logic [39:0] peak_bytes;
        logic [31:0] swap_in_total;
        logic [31:0] eviction_total;
        logic [31:0] use_count;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [31:0] size;
        logic        resident;
        logic [63:0] last_tick;
        logic [31:0] uses;
    } entry_rec_t;

endpackage

### hw/rtl/blru_mem.sv
// entry table: one write port, one registered read port
module blru_mem #(
    parameter int DEPTH = blru_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  blru_pkg::entry_rec_t   wdata,
    input  logic [AW-1:0]          raddr,
    output blru_pkg::entry_rec_t   rdata
);
    import blru_pkg::*;

    entry_rec_t mem [DEPTH];
    entry_rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/blru_ctrl.sv
// sequencer: request decode, lru victim scan, counters and result register
module blru_ctrl #(
    parameter int MAX_ENTRIES = blru_pkg::MAX_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [39:0]         byte_budget,
    input  logic                s_valid,
    output logic                s_ready,
    input  blru_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output blru_pkg::out_word_t m_data
);
    import blru_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    state_t      state_reg, state_next;
    in_word_t    in_reg, in_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [63:0] tick_reg, tick_next;
    logic [39:0] used_reg, used_next;
    logic [39:0] peak_reg, peak_next;
    logic [31:0] swap_reg, swap_next;
    logic [31:0] evict_reg, evict_next;
    logic        found_reg, found_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    entry_rec_t  best_rec_reg, best_rec_next;
    entry_rec_t  t_rec_reg, t_rec_next;
    status_t     res_status_reg, res_status_next;
    logic [5:0]  res_id_reg, res_id_next;
    logic [31:0] res_uses_reg, res_uses_next;
    logic        res_last_reg, res_last_next;
    out_word_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_rec_t    mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_rec_t    mem_rdata;

    logic [5:0]    id_m1;
    logic [AW-1:0] t_idx;
    logic          valid_id;
    logic [40:0]   sum41;
    logic          over_budget;
    logic [39:0]   used_add_sat;
    logic          out_free;
    logic          more_victims;

    blru_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign id_m1        = in_reg.entry_id - 6'd1;
    assign t_idx        = id_m1[AW-1:0];
    assign valid_id     = (in_reg.entry_id != 6'd0) && (in_reg.entry_id <= 6'(count_reg));
    assign sum41        = {1'b0, used_reg} + {9'd0, t_rec_reg.size};
    assign over_budget  = sum41 > {1'b0, byte_budget};
    assign used_add_sat = sum41[40] ? {40{1'b1}} : sum41[39:0];
    assign out_free     = !out_valid_reg || m_ready;
    assign more_victims = over_budget && (k_reg < CW'(MAX_ENTRIES - 1));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if ((in_reg.mode == MODE_ACCESS || in_reg.mode == MODE_EVICT) && valid_id)
                    state_next = ST_READ_T;
                else
                    state_next = ST_EMIT;
            end
            ST_READ_T: begin
                if (in_reg.mode == MODE_ACCESS && !(mem_rdata.resident && mem_rdata.size != 32'd0))
                    state_next = ST_FIT;
                else
                    state_next = ST_EMIT;
            end
            ST_FIT: begin
                state_next = more_victims ? ST_SCAN_RD : ST_PAGE;
            end
            ST_SCAN_RD: begin
                state_next = (idx_reg >= count_reg) ? ST_SCAN_DONE : ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_DONE: begin
                state_next = found_reg ? ST_EMIT : ST_PAGE;
            end
            ST_PAGE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = res_last_reg ? ST_IDLE : ST_FIT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_next         = in_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        tick_next       = tick_reg;
        used_next       = used_reg;
        peak_next       = peak_reg;
        swap_next       = swap_reg;
        evict_next      = evict_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_rec_next   = best_rec_reg;
        t_rec_next      = t_rec_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_uses_next   = res_uses_reg;
        res_last_next   = res_last_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_waddr       = t_idx;
        mem_wdata       = t_rec_reg;
        mem_raddr       = t_idx;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) in_next = s_data;
            end
            ST_CHECK: begin
                res_status_next = STAT_ERROR;
                res_id_next     = 6'd0;
                res_uses_next   = 32'd0;
                res_last_next   = 1'b1;
                if (in_reg.mode == MODE_REGISTER && count_reg < CW'(MAX_ENTRIES)) begin
                    mem_we          = 1'b1;
                    mem_waddr       = count_reg[AW-1:0];
                    mem_wdata       = '{size: in_reg.entry_bytes, resident: 1'b0,
                                        last_tick: 64'd0, uses: 32'd0};
                    count_next      = count_reg + CW'(1);
                    res_status_next = STAT_REGISTERED;
                    res_id_next     = 6'(count_reg) + 6'd1;
                end
            end
            ST_READ_T: begin
                res_id_next = in_reg.entry_id;
                if (in_reg.mode == MODE_EVICT) begin
                    if (!mem_rdata.resident) begin
                        res_status_next = STAT_NOT_RES;
                    end else begin
                        mem_we             = 1'b1;
                        mem_wdata          = mem_rdata;
                        mem_wdata.resident = 1'b0;
                        used_next  = (used_reg >= {8'd0, mem_rdata.size}) ?
                                     used_reg - {8'd0, mem_rdata.size} : 40'd0;
                        evict_next = evict_reg + 32'd1;
                        res_status_next = STAT_EVICTED;
                    end
                end else begin
                    tick_next            = tick_reg + 64'd1;
                    t_rec_next           = mem_rdata;
                    t_rec_next.last_tick = tick_reg + 64'd1;
                    t_rec_next.uses      = mem_rdata.uses + 32'd1;
                    mem_we               = 1'b1;
                    mem_wdata            = t_rec_next;
                    k_next               = '0;
                    res_status_next      = STAT_HIT;
                    res_uses_next        = mem_rdata.uses + 32'd1;
                end
            end
            ST_FIT: begin
                idx_next   = '0;
                found_next = 1'b0;
            end
            ST_SCAN_RD: begin
                mem_raddr = idx_reg[AW-1:0];
            end
            ST_SCAN_CMP: begin
                // first resident candidate seeds the search, ties keep the lower index
                if (idx_reg[AW-1:0] != t_idx && mem_rdata.resident &&
                    (!found_reg || mem_rdata.last_tick < best_rec_reg.last_tick)) begin
                    best_idx_next = idx_reg[AW-1:0];
                    best_rec_next = mem_rdata;
                    found_next    = 1'b1;
                end
                idx_next = idx_reg + CW'(1);
            end
            ST_SCAN_DONE: begin
                if (found_reg) begin
                    mem_we             = 1'b1;
                    mem_waddr          = best_idx_reg;
                    mem_wdata          = best_rec_reg;
                    mem_wdata.resident = 1'b0;
                    used_next  = (used_reg >= {8'd0, best_rec_reg.size}) ?
                                 used_reg - {8'd0, best_rec_reg.size} : 40'd0;
                    evict_next      = evict_reg + 32'd1;
                    k_next          = k_reg + CW'(1);
                    res_status_next = STAT_VICTIM;
                    res_id_next     = 6'(best_idx_reg) + 6'd1;
                    res_uses_next   = 32'd0;
                    res_last_next   = 1'b0;
                end
            end
            ST_PAGE: begin
                t_rec_next.resident = 1'b1;
                mem_we              = 1'b1;
                mem_wdata           = t_rec_reg;
                mem_wdata.resident  = 1'b1;
                used_next           = used_add_sat;
                if (used_add_sat > peak_reg) peak_next = used_add_sat;
                swap_next           = swap_reg + 32'd1;
                res_status_next     = STAT_PAGED_IN;
                res_id_next         = in_reg.entry_id;
                res_uses_next       = t_rec_reg.uses;
                res_last_next       = 1'b1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_next = '{status: res_status_reg, result_id: res_id_reg,
                                 bytes_in_use: used_reg, peak_bytes: peak_reg,
                                 swap_in_total: swap_reg, eviction_total: evict_reg,
                                 use_count: res_uses_reg, last: res_last_reg};
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            tick_reg      <= 64'd0;
            used_reg      <= 40'd0;
            peak_reg      <= 40'd0;
            swap_reg      <= 32'd0;
            evict_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tick_reg      <= tick_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            swap_reg      <= swap_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        k_reg          <= k_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_rec_reg   <= best_rec_next;
        t_rec_reg      <= t_rec_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_uses_reg   <= res_uses_next;
        res_last_reg   <= res_last_next;
        out_reg        <= out_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_peak_covers_used: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= used_reg || state_reg == ST_SCAN_DONE || state_reg == ST_READ_T ||
        $past(state_reg) != ST_PAGE)
        else $error("peak below resident bytes after page-in");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !mem_we)
        else $error("table written while idle");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_CHECK)
        else $error("accepted word not decoded");

endmodule

### hw/rtl/budgeted_lru_residency_manager_top.sv
// top level: config register port and residency sequencer
//
//  channel | ports           | moves
//  --------+-----------------+------------------------------------------
//  request | s_valid/s_ready | word: mode, entry_id, entry_bytes
//  result  | m_valid/m_ready | word per result, last marks the final one
//  config  | apb (psel..)    | byte_budget at address 0, 64-bit data
//
// one request at a time; s_ready is high only while the sequencer is idle
// an access miss scans all registered entries once per victim, one after another
// (single read port of the entry table), and evicts up to 31 victims in a full
// table of the default depth before the final page-in
// aresetn is synchronous; table contents are not cleared, no init sweep
// a stalled result holds the sequencer in its emit step until taken
module budgeted_lru_residency_manager_top #(
    parameter int MAX_ENTRIES = blru_pkg::MAX_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  blru_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output blru_pkg::out_word_t m_data
);
    import blru_pkg::*;

    logic [39:0] budget_reg, budget_next;

    assign pready = 1'b1;

    always_comb begin
        budget_next = budget_reg;
        if (psel && penable && pwrite && paddr[3] == REG_BYTE_BUDGET) begin
            // zero selects the default budget
            budget_next = (pwdata[39:0] == 40'd0) ? DEFAULT_BUDGET : pwdata[39:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= DEFAULT_BUDGET;
        end else begin
            budget_reg <= budget_next;
        end
    end

    assign prdata = (paddr[3] == REG_BYTE_BUDGET) ? {24'd0, budget_reg} : 64'd0;

    blru_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_budget (budget_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### bench/budgeted_lru_residency_manager_top_tb.sv
// testbench of the budgeted lru residency manager: random and directed requests, scoreboard
`timescale 1ns / 100ps

module budgeted_lru_residency_manager_top_tb;
    import blru_pkg::*;

    localparam int NENT = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [39:0] MASK40 = 40'hFF_FFFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;

    budgeted_lru_residency_manager_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    logic [39:0] budget_q;
    int          count_q;
    logic [31:0] size_q [NENT];
    logic        res_q [NENT];
    logic [63:0] tick_at_q [NENT];
    logic [31:0] uses_q [NENT];
    logic [63:0] tick_q;
    logic [39:0] used_q;
    logic [39:0] peak_q;
    logic [31:0] swaps_q;
    logic [31:0] evicts_q;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int words_sent = 0;
    int words_seen = 0;
    int victims_seen = 0;
    int idle_cycles = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void predict_reset();
        budget_q = DEFAULT_BUDGET;
        count_q = 0;
        tick_q = '0;
        used_q = '0;
        peak_q = '0;
        swaps_q = '0;
        evicts_q = '0;
    endfunction

    function automatic void push_result(status_t st, logic [5:0] id, logic [31:0] uses,
                                        logic lst);
        out_word_t w;
        w.status = st;
        w.result_id = id;
        w.bytes_in_use = used_q;
        w.peak_bytes = peak_q;
        w.swap_in_total = swaps_q;
        w.eviction_total = evicts_q;
        w.use_count = uses;
        w.last = lst;
        expected_words.push_back(w);
    endfunction

    function automatic void release_entry(int i);
        res_q[i] = 1'b0;
        used_q = (used_q >= {8'd0, size_q[i]}) ? used_q - {8'd0, size_q[i]} : '0;
        evicts_q++;
    endfunction

    function automatic void predict_residency(in_word_t w);
        int t, v, k;
        bit found, ok;
        logic [40:0] sum;
        ok = w.entry_id >= 1 && w.entry_id <= count_q;
        if (w.mode == MODE_REGISTER) begin
            if (count_q >= NENT) begin
                push_result(STAT_ERROR, '0, '0, 1'b1);
            end else begin
                size_q[count_q] = w.entry_bytes;
                res_q[count_q] = 1'b0;
                tick_at_q[count_q] = '0;
                uses_q[count_q] = '0;
                count_q++;
                push_result(STAT_REGISTERED, 6'(count_q), '0, 1'b1);
            end
        end else if (w.mode == MODE_EVICT) begin
            if (!ok) begin
                push_result(STAT_ERROR, '0, '0, 1'b1);
            end else if (!res_q[w.entry_id - 1]) begin
                push_result(STAT_NOT_RES, w.entry_id, '0, 1'b1);
            end else begin
                release_entry(w.entry_id - 1);
                push_result(STAT_EVICTED, w.entry_id, '0, 1'b1);
            end
        end else if (w.mode == MODE_ACCESS && ok) begin
            t = w.entry_id - 1;
            tick_q++;
            tick_at_q[t] = tick_q;
            uses_q[t]++;
            if (res_q[t] && size_q[t] != 0) begin
                push_result(STAT_HIT, w.entry_id, uses_q[t], 1'b1);
            end else begin
                k = 0;
                forever begin
                    sum = {1'b0, used_q} + {9'd0, size_q[t]};
                    if (sum <= {1'b0, budget_q}) break;
                    found = 0;
                    v = 0;
                    for (int i = 0; i < count_q; i++) begin
                        if (i != t && res_q[i] && (!found || tick_at_q[i] < tick_at_q[v])) begin
                            v = i;
                            found = 1;
                        end
                    end
                    if (!found || k >= NENT - 1) break;
                    release_entry(v);
                    push_result(STAT_VICTIM, 6'(v + 1), '0, 1'b0);
                    k++;
                end
                res_q[t] = 1'b1;
                sum = {1'b0, used_q} + {9'd0, size_q[t]};
                used_q = sum[40] ? MASK40 : sum[39:0];
                if (used_q > peak_q) peak_q = used_q;
                swaps_q++;
                push_result(STAT_PAGED_IN, w.entry_id, uses_q[t], 1'b1);
            end
        end else begin
            push_result(STAT_ERROR, '0, '0, 1'b1);
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_residency(s_data);
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("** budgeted_lru_residency_manager_top: FAILED **");
                $finish;
            end
            if (m_valid && m_ready) begin
                words_seen++;
                if (m_data.status == STAT_VICTIM) victims_seen++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %p", m_data);
                end else begin
                    e = expected_words.pop_front();
                    if (m_data !== e) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, m_data);
                    end
                end
            end
        end
    end

    task automatic apb_write(logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'd0; pwdata <= val; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        budget_q = (val[39:0] == 0) ? DEFAULT_BUDGET : val[39:0];
    endtask

    task automatic drain_results();
        while (pending_words.size() > 0 || s_valid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic in_word_t mk(logic [1:0] md, logic [5:0] id, logic [31:0] b);
        in_word_t w;
        w.mode = md; w.entry_id = id; w.entry_bytes = b;
        return w;
    endfunction

    // mostly small sizes so that the budget forces evictions
    function automatic logic [31:0] rand_size();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(4000);
        endcase
    endfunction

    function automatic in_word_t rand_word(int n_reg);
        int r;
        r = $urandom_range(99);
        if (r < 8) return mk(MODE_REGISTER, 6'($urandom()), rand_size());
        if (r < 75) return mk(MODE_ACCESS, 6'($urandom_range(n_reg, 1)), $urandom());
        if (r < 88) return mk(MODE_EVICT, 6'($urandom_range(n_reg, 1)), $urandom());
        return mk(2'($urandom()), 6'($urandom()), $urandom());
    endfunction

    initial begin
        logic [63:0] budgets [4];
        predict_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: errors on empty table, edges of sizes, fills, zero size
        apb_write(64'd10000);
        pending_words.push_back(mk(MODE_ACCESS, 6'd0, '0));
        pending_words.push_back(mk(MODE_EVICT, 6'd1, '0));
        pending_words.push_back(mk(2'd3, 6'd63, 32'hFFFF_FFFF));
        pending_words.push_back(mk(MODE_REGISTER, 6'd63, 32'd0));
        pending_words.push_back(mk(MODE_REGISTER, 6'd0, 32'd4000));
        pending_words.push_back(mk(MODE_REGISTER, 6'd0, 32'd5000));
        pending_words.push_back(mk(MODE_REGISTER, 6'd0, 32'hFFFF_FFFF));
        pending_words.push_back(mk(MODE_ACCESS, 6'd1, '0));
        pending_words.push_back(mk(MODE_ACCESS, 6'd1, '0));
        pending_words.push_back(mk(MODE_ACCESS, 6'd2, '0));
        pending_words.push_back(mk(MODE_ACCESS, 6'd3, '0));
        pending_words.push_back(mk(MODE_ACCESS, 6'd4, '0));
        pending_words.push_back(mk(MODE_ACCESS, 6'd5, '0));
        pending_words.push_back(mk(MODE_EVICT, 6'd3, '0));
        pending_words.push_back(mk(MODE_EVICT, 6'd3, '0));
        pending_words.push_back(mk(MODE_EVICT, 6'd1, '0));
        pending_words.push_back(mk(MODE_ACCESS, 6'd2, 32'hFFFF_FFFF));
        drain_results();

        // directed: fill the table, registering past its depth so that the last three are refused
        for (int i = 0; i < 30; i++)
            pending_words.push_back(mk(MODE_REGISTER, 6'($urandom()), 32'($urandom_range(600))));
        pending_words.push_back(mk(MODE_REGISTER, 6'd0, 32'd1));
        drain_results();

        // random phases over several budgets, extremes included
        budgets[0] = 64'd0;
        budgets[1] = 64'd1;
        budgets[2] = 64'hFFFF_FF_FFFF_FFFF;
        budgets[3] = 64'd6000;
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(ph == 2 ? 64'h0000_00FF_FFFF_FFFF : budgets[ph]);
            if (ph == 3) apb_write(budgets[2]);
            if (ph == 3) apb_write(64'd6000);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int i = 0; i < 80; i++) pending_words.push_back(rand_word(count_q + 2));
            drain_results();
        end

        $display("sent %0d request words, checked %0d result words (%0d victim evictions)",
                 words_sent, words_seen, victims_seen);
        $display("budgets from one byte to the 40-bit maximum, idle and stall mixes applied");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("** budgeted_lru_residency_manager_top: PASSED **");
        end else begin
            $display("** budgeted_lru_residency_manager_top: FAILED **");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/blru_pkg.sv
hw/rtl/blru_mem.sv
hw/rtl/blru_ctrl.sv
hw/rtl/budgeted_lru_residency_manager_top.sv
bench/budgeted_lru_residency_manager_top_tb.sv
